@@ src/mwbg_pkg.sv @@
// Shared types and constants for the Morse wavelet bin generator.
// No dependencies; imported by every module of the block.
package mwbg_pkg;

  localparam int MAX_SIZE_LOG2 = 16;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_BETA  = 2'd0;
  localparam logic [1:0] REG_GAMMA = 2'd1;
  localparam logic [1:0] REG_SIZE  = 2'd2;

  localparam logic [15:0] BETA_RESET     = 16'd23040;
  localparam logic [11:0] GAMMA_RESET    = 12'd768;
  localparam logic [16:0] SIZE_RESET     = 17'd1024;
  localparam logic [15:0] FALLBACK_BETA  = 16'd23040;
  localparam logic [11:0] FALLBACK_GAMMA = 12'd768;

  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [30:0] INVLN2_Q30 = 31'd1549082005;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  // exp argument limits, Q.24
  localparam logic signed [39:0] EXP_ARG_MIN = -40'sd3355443200;  // -200
  localparam logic signed [39:0] EXP_ARG_MAX = 40'sd1006632960;   // 60
  // exponent window of the wavelet, Q.24 (80.0)
  localparam logic signed [63:0] X_LIMIT = 64'sd1342177280;

  localparam logic [17:0] OUT_MAX = 18'd131072;

  // ceil(2^34 / i): exact floor division by i for 30-bit dividends
  localparam logic [33:0] TAYLOR_RECIP [2:13] = '{
    34'd8589934592, 34'd5726623062, 34'd4294967296, 34'd3435973837,
    34'd2863311531, 34'd2454267027, 34'd2147483648, 34'd1908874354,
    34'd1717986919, 34'd1561806290, 34'd1431655766, 34'd1321528399
  };

  // sideband of the log pipeline
  typedef struct packed {
    logic v;    // item beat
    logic cfg;  // derivation beat (log of beta or gamma)
    logic bad;  // bin outside the positive half
  } ln_side_t;

  // sideband of the exp pipeline
  typedef struct packed {
    logic               v;
    logic               bad;   // result forced to zero
    logic               sat;   // result forced to full scale
    logic signed [31:0] lnw;   // ln w, carried for the exponent sum
  } exp_side_t;

endpackage

@@ src/mwbg_ln.sv @@
// Pipelined natural log, result in Q.24, of x / 2^fbits.
// Uses mwbg_pkg; normalise, 24 squaring stages, scale by ln2.
module mwbg_ln import mwbg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [31:0]        x,
  input  logic [4:0]         fbits,
  input  ln_side_t           side_in,
  output logic signed [31:0] lnv,
  output ln_side_t           side_out
);

  logic [31:0] x0, x1;
  logic [4:0]  fb0, fb1, p1, p_enc;
  ln_side_t    sd0, sd1;

  logic [30:0]        m   [0:24];
  logic [23:0]        acc [0:24];
  logic signed [6:0]  eo  [0:24];
  ln_side_t           sd  [0:24];

  logic [31:0]        sh;
  logic signed [31:0] l2;
  logic signed [62:0] prod;

  always_comb begin
    p_enc = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x0[i]) p_enc = 5'(i);
    end
  end

  assign sh = (p1 >= 5'd30) ? (x1 >> (p1 - 5'd30)) : (x1 << (5'd30 - p1));

  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= x;
      fb0 <= fbits;
      x1  <= x0;
      fb1 <= fb0;
      p1  <= p_enc;
      m[0]   <= sh[30:0];
      acc[0] <= '0;
      eo[0]  <= $signed({2'b00, p1}) - $signed({2'b00, fb1});
    end
    if (rst) begin
      sd0   <= '0;
      sd1   <= '0;
      sd[0] <= '0;
    end else if (en) begin
      sd0   <= side_in;
      sd1   <= sd0;
      sd[0] <= sd1;
    end
  end

  for (genvar j = 1; j <= 24; j++) begin : g_sq
    logic [61:0] mm;
    logic [31:0] hi;
    assign mm = m[j-1] * m[j-1];
    assign hi = mm[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        m[j]   <= hi[31] ? hi[31:1] : hi[30:0];
        acc[j] <= {acc[j-1][22:0], hi[31]};
        eo[j]  <= eo[j-1];
      end
      if (rst) begin
        sd[j] <= '0;
      end else if (en) begin
        sd[j] <= sd[j-1];
      end
    end
  end

  // integer part and fraction sit side by side: no add needed
  assign l2   = {eo[24][6], eo[24], acc[24]};
  assign prod = l2 * $signed({1'b0, LN2_Q30});

  always_ff @(posedge clk) begin
    if (en) lnv <= prod[61:30];
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= sd[24];
    end
  end

endmodule

@@ src/mwbg_exp.sv @@
// Pipelined exp of a Q.24 argument, unsigned Q.24 result capped at 2^61.
// Uses mwbg_pkg; 2^(x/ln2) with a 13-term Taylor series on the fraction.
module mwbg_exp import mwbg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic signed [39:0] x,
  input  exp_side_t          side_in,
  output logic [61:0]        res,
  output exp_side_t          side_out
);

  typedef struct packed {
    logic               under;
    logic               over;
    logic signed [10:0] n;
    logic [29:0]        r;
    logic [29:0]        term;
    logic [30:0]        sum;
  } chain_t;

  logic signed [39:0] x0;
  exp_side_t          sd0, sd1, sd2;
  logic               under1, over1, under2, over2;
  logic signed [48:0] ph;
  logic [46:0]        pl;
  logic signed [10:0] n2;
  logic [23:0]        f2;

  chain_t     ck  [0:24];
  exp_side_t  cks [0:24];

  logic               under0, over0;
  logic signed [32:0] xc;
  logic signed [64:0] ysum;
  logic [53:0]        rprod;
  logic signed [11:0] shift;
  logic [11:0]        nshift;
  logic [61:0]        res_nx;

  assign under0 = x0 < EXP_ARG_MIN;
  assign over0  = x0 > EXP_ARG_MAX;
  assign xc     = (under0 || over0) ? 33'sd0 : x0[32:0];
  assign ysum   = $signed({ph, 16'b0}) + $signed({18'b0, pl});
  assign rprod  = f2 * LN2_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      x0     <= x;
      under1 <= under0;
      over1  <= over0;
      ph     <= $signed(xc[32:16]) * $signed({1'b0, INVLN2_Q30});
      pl     <= xc[15:0] * INVLN2_Q30;
      under2 <= under1;
      over2  <= over1;
      n2     <= ysum[64:54];
      f2     <= ysum[53:30];
      ck[0].under <= under2;
      ck[0].over  <= over2;
      ck[0].n     <= n2;
      ck[0].r     <= rprod[53:24];
      ck[0].term  <= rprod[53:24];
      ck[0].sum   <= {1'b1, 30'b0} + {1'b0, rprod[53:24]};
    end
    if (rst) begin
      sd0    <= '0;
      sd1    <= '0;
      sd2    <= '0;
      cks[0] <= '0;
    end else if (en) begin
      sd0    <= side_in;
      sd1    <= sd0;
      sd2    <= sd1;
      cks[0] <= sd2;
    end
  end

  for (genvar i = 2; i <= 13; i++) begin : g_term
    localparam int A = 2 * i - 3;
    localparam int B = 2 * i - 2;
    logic [59:0] tp;
    logic [63:0] qp;
    assign tp = ck[A-1].term * ck[A-1].r;
    assign qp = ck[A].term * TAYLOR_RECIP[i];
    always_ff @(posedge clk) begin
      if (en) begin
        ck[A] <= '{under: ck[A-1].under, over: ck[A-1].over, n: ck[A-1].n,
                   r: ck[A-1].r, term: tp[59:30], sum: ck[A-1].sum};
        ck[B] <= '{under: ck[A].under, over: ck[A].over, n: ck[A].n,
                   r: ck[A].r, term: qp[63:34],
                   sum: ck[A].sum + {1'b0, qp[63:34]}};
      end
      if (rst) begin
        cks[A] <= '0;
        cks[B] <= '0;
      end else if (en) begin
        cks[A] <= cks[A-1];
        cks[B] <= cks[A];
      end
    end
  end

  assign shift  = {ck[24].n[10], ck[24].n} - 12'sd6;
  assign nshift = 12'd0 - shift;

  always_comb begin
    if (ck[24].over) begin
      res_nx = {1'b1, 61'b0};
    end else if (ck[24].under) begin
      res_nx = '0;
    end else if (!shift[11]) begin
      if (shift[10:0] > 11'd30) res_nx = {1'b1, 61'b0};
      else res_nx = {31'b0, ck[24].sum} << shift[4:0];
    end else begin
      if (nshift >= 12'd31) res_nx = '0;
      else res_nx = {31'b0, ck[24].sum} >> nshift[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_nx;
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= cks[24];
    end
  end

endmodule

@@ src/morse_wavelet_bin_generator.sv @@
// Top level of the generalized Morse wavelet bin generator.
// Uses mwbg_pkg, mwbg_ln (log pipeline) and mwbg_exp (two exp pipelines).
//
//  port group     dir   handshake              payload
//  in             in    in_valid / in_stall    bin_index     [15:0]
//  out            out   out_valid / out_stall  wavelet_value [17:0] Q1.17
//  cfg            in    cfg_valid / cfg_ready  cfg_index [1:0], cfg_data [16:0]
//
// One beat in per cycle, one beat out per cycle, while neither stalled nor rebuilding
// (stages: input register, 28-stage log, 29-stage exp of w^gamma, two stages for
// the exponent sum, 29-stage exp of the result, output register).
// All stages advance together; a stalled output freezes the whole pipe.
// After reset and after each register write the derived constants are
// rebuilt (two log beats through the log pipe, then two or three 40-step serial
// divisions) with in_stall high and cfg_ready low.
module morse_wavelet_bin_generator import mwbg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] bin_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [17:0] wavelet_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  typedef enum logic [2:0] {D_LNB, D_LNG, D_WAIT, D_DIV, D_DONE} dstate_t;
  typedef enum logic [1:0] {SEL_PPG, SEL_LWC, SEL_FS} dsel_t;

  localparam logic [5:0] DIV_LAST = 6'd39;

  // configuration registers
  logic [15:0] beta_q8;
  logic [11:0] gamma_q8;
  logic [16:0] transform_size;

  // derived constants
  logic signed [31:0] log_peak_freq;
  logic [31:0]        peak_pow_gamma;
  logic [31:0]        freq_step;

  logic [15:0] b_eff;
  logic [11:0] g_eff;
  logic [16:0] size_c;
  logic [16:0] half_bins;

  logic en, busy;

  // derivation sequencer
  dstate_t            dstate;
  dsel_t              dsel;
  logic               ln_cnt;
  logic signed [31:0] ln_b;
  logic signed [31:0] lnr_c;
  logic [31:0]        lnr_abs;
  logic               lnr_neg;
  logic [39:0]        lnr_mag;
  logic [39:0]        lnr_mag_q;
  logic [39:0]        dv_n;
  logic [16:0]        dv_d;
  logic [16:0]        dv_r;
  logic [5:0]         dv_cnt;
  logic [17:0]        rem_sh;
  logic               rem_ge;
  logic [16:0]        rem_nx;
  logic [39:0]        n_nx;
  logic [31:0]        lwc_sat;

  // item pipe
  logic        s1_v, s1_bad;
  logic [15:0] s1_k;
  logic [47:0] w_full;
  logic [31:0] ln_x;
  logic [4:0]  ln_fbits;
  ln_side_t    ln_si, ln_so;
  logic signed [31:0] lnw;

  logic signed [44:0] lg;
  exp_side_t          e1_si, e1_so;
  logic [61:0]        wg;

  logic signed [32:0] dlog;
  logic signed [49:0] s4_t;
  logic [61:0]        s4_wg;
  logic               s4_v, s4_bad;
  logic signed [63:0] x_nx;
  logic signed [63:0] s5_x;
  logic               s5_v, s5_bad;

  logic               x_zero, x_sat;
  logic signed [39:0] e2_x;
  exp_side_t          e2_si, e2_so;
  logic [61:0]        e2;

  // zero shape parameter falls back to beta 90, gamma 3
  assign b_eff = (beta_q8 == '0 || gamma_q8 == '0) ? FALLBACK_BETA : beta_q8;
  assign g_eff = (beta_q8 == '0 || gamma_q8 == '0) ? FALLBACK_GAMMA : gamma_q8;
  assign size_c = ({15'b0, transform_size} > (32'd1 << MAX_SIZE_LOG2)) ?
                  17'(32'd1 << MAX_SIZE_LOG2) : transform_size;
  assign half_bins = size_c >> 1;

  assign en        = !(out_valid && out_stall);
  assign busy      = dstate != D_DONE;
  assign in_stall  = !en || busy;
  assign cfg_ready = dstate == D_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_q8        <= BETA_RESET;
      gamma_q8       <= GAMMA_RESET;
      transform_size <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BETA:  beta_q8        <= cfg_data[15:0];
        REG_GAMMA: gamma_q8       <= cfg_data[11:0];
        REG_SIZE:  transform_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Derivation: ln(beta) and ln(gamma) through the shared log pipe,
  // then beta/gamma, ln(wc) = ln(beta/gamma)/gamma and 2pi/size on
  // one restoring divider, one quotient bit per cycle.
  // ---------------------------------------------------------------
  assign lnr_c   = ln_b - lnw;
  assign lnr_abs = lnr_c[31] ? 32'(-lnr_c) : lnr_c;
  assign lnr_mag = {lnr_abs, 8'b0};

  assign rem_sh = {dv_r, dv_n[39]};
  assign rem_ge = rem_sh >= {1'b0, dv_d};
  assign rem_nx = rem_ge ? 17'(rem_sh - {1'b0, dv_d}) : rem_sh[16:0];
  assign n_nx   = {dv_n[38:0], rem_ge};

  // C-style truncating quotient, saturated to the int32 range
  always_comb begin
    if (!lnr_neg) begin
      lwc_sat = (n_nx > 40'h007FFFFFFF) ? 32'h7FFFFFFF : n_nx[31:0];
    end else begin
      lwc_sat = (n_nx > 40'h0080000000) ? 32'h80000000 : (~n_nx[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_LNB;
      ln_cnt <= 1'b0;
    end else begin
      case (dstate)
        D_LNB: if (en) dstate <= D_LNG;
        D_LNG: begin
          if (en) begin
            dstate <= D_WAIT;
            ln_cnt <= 1'b0;
          end
        end
        D_WAIT: begin
          if (en && ln_so.cfg) begin
            if (!ln_cnt) begin
              ln_b   <= lnw;
              ln_cnt <= 1'b1;
            end else begin
              lnr_neg <= lnr_c[31];
              lnr_mag_q <= lnr_mag;
              dv_n   <= {8'b0, b_eff, 16'b0};
              dv_d   <= {5'b0, g_eff};
              dv_r   <= '0;
              dv_cnt <= '0;
              dsel   <= SEL_PPG;
              dstate <= D_DIV;
            end
          end
        end
        D_DIV: begin
          if (dv_cnt == DIV_LAST) begin
            dv_r   <= '0;
            dv_cnt <= '0;
            case (dsel)
              SEL_PPG: begin
                peak_pow_gamma <= n_nx[31:0];
                dv_n <= lnr_mag_q;
                dsel <= SEL_LWC;
              end
              SEL_LWC: begin
                log_peak_freq <= $signed(lwc_sat);
                if (size_c == '0) begin
                  freq_step <= '0;
                  dstate    <= D_DONE;
                end else begin
                  dv_n <= {8'b0, TWO_PI_Q29};
                  dv_d <= size_c;
                  dsel <= SEL_FS;
                end
              end
              SEL_FS: begin
                freq_step <= n_nx[31:0];
                dstate    <= D_DONE;
              end
              default: dstate <= D_DONE;
            endcase
          end else begin
            dv_n   <= n_nx;
            dv_r   <= rem_nx;
            dv_cnt <= dv_cnt + 6'd1;
          end
        end
        D_DONE: begin
          if (cfg_valid && cfg_ready &&
              (cfg_index inside {REG_BETA, REG_GAMMA, REG_SIZE})) begin
            dstate <= D_LNB;
          end
        end
        default: dstate <= D_DONE;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Item pipe
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s1_k   <= bin_index;
      s1_bad <= (bin_index == '0) || ({1'b0, bin_index} > half_bins);
    end
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_valid && !busy;
  end

  // w = k * 2pi/size, Q3.29; stays below 2^31 for bins in range
  assign w_full = s1_k * freq_step;

  // log pipe input: derivation beats take it while the input is held off
  always_comb begin
    case (dstate)
      D_LNB: begin
        ln_x     = {16'b0, b_eff};
        ln_fbits = 5'd0;
        ln_si    = '{v: 1'b0, cfg: 1'b1, bad: 1'b0};
      end
      D_LNG: begin
        ln_x     = {20'b0, g_eff};
        ln_fbits = 5'd0;
        ln_si    = '{v: 1'b0, cfg: 1'b1, bad: 1'b0};
      end
      default: begin
        ln_x     = w_full[31:0];
        ln_fbits = 5'd29;
        ln_si    = '{v: s1_v, cfg: 1'b0, bad: s1_bad};
      end
    endcase
  end

  mwbg_ln u_ln (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .x        (ln_x),
    .fbits    (ln_fbits),
    .side_in  (ln_si),
    .lnv      (lnw),
    .side_out (ln_so)
  );

  // w^gamma = exp(gamma * ln w)
  assign lg    = lnw * $signed({1'b0, g_eff});
  assign e1_si = '{v: ln_so.v, bad: ln_so.bad, sat: 1'b0, lnw: lnw};

  mwbg_exp u_exp_pow (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .x        (40'(lg >>> 8)),
    .side_in  (e1_si),
    .res      (wg),
    .side_out (e1_so)
  );

  // beta * (ln w - ln wc)
  assign dlog = {e1_so.lnw[31], e1_so.lnw} - {log_peak_freq[31], log_peak_freq};

  always_ff @(posedge clk) begin
    if (en) begin
      s4_t   <= dlog * $signed({1'b0, b_eff});
      s4_wg  <= wg;
      s4_bad <= e1_so.bad;
    end
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= e1_so.v;
  end

  // X = beta*(ln w - ln wc) + wc^gamma - w^gamma, Q.24
  assign x_nx = 64'(s4_t >>> 8) + $signed({24'b0, peak_pow_gamma, 8'b0})
              - $signed({2'b0, s4_wg});

  always_ff @(posedge clk) begin
    if (en) begin
      s5_x   <= x_nx;
      s5_bad <= s4_bad;
    end
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= s4_v;
  end

  // outside the window gives zero, non-negative X saturates
  assign x_zero = s5_bad || (s5_x <= -X_LIMIT) || (s5_x >= X_LIMIT);
  assign x_sat  = !x_zero && !s5_x[63];
  assign e2_x   = (x_zero || x_sat) ? 40'sd0 : s5_x[39:0];
  assign e2_si  = '{v: s5_v, bad: x_zero, sat: x_sat, lnw: 32'sd0};

  mwbg_exp u_exp_out (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .x        (e2_x),
    .side_in  (e2_si),
    .res      (e2),
    .side_out (e2_so)
  );

  // output register: Q.24 to Q1.17 by truncation, capped at 1.0
  always_ff @(posedge clk) begin
    if (en) begin
      if (e2_so.bad) wavelet_value <= '0;
      else if (e2_so.sat) wavelet_value <= OUT_MAX;
      else if (e2[61:7] > {37'b0, OUT_MAX}) wavelet_value <= OUT_MAX;
      else wavelet_value <= e2[24:7];
    end
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= e2_so.v;
  end

endmodule

@@ sim/mwbg_checker.sv @@
// Checker for the Morse wavelet bin generator: watches the bin, result and
// register channels, predicts each wavelet value and compares in order.
// Depends on mwbg_pkg.
`timescale 1ns / 100ps
module mwbg_checker import mwbg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] bin_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [17:0] wavelet_value,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam longint ONE_Q24 = 64'sd16777216;

  logic [15:0] beta_r;
  logic [11:0] gamma_r;
  logic [16:0] size_r;
  logic signed [31:0] ln_peak;
  logic [31:0] peak_pow;
  logic [31:0] step_q29;
  logic [16:0] half_n;

  logic [17:0] want_q[$];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint log_q24(logic [63:0] x, int fbits);
    int p;
    logic [63:0] m, acc;
    longint l2;
    if (x == 0) return -(64 * ONE_Q24);
    p = 63;
    while (x[p] == 1'b0) p--;
    m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
    acc = 0;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      acc = acc << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        acc[0] = 1'b1;
      end
    end
    l2 = longint'(p - fbits) * ONE_Q24 + longint'(acc);
    return shr_floor(l2 * longint'(LN2_Q30), 30);
  endfunction

  function automatic logic [63:0] exp_q24(longint x);
    longint y, n, f, sh;
    logic [63:0] r, term, sum;
    if (x < -200 * ONE_Q24) return 0;
    if (x > 60 * ONE_Q24) return 64'd1 << 61;
    y = shr_floor(x * longint'(INVLN2_Q30), 30);
    n = shr_floor(y, 24);
    f = y - n * ONE_Q24;
    r = (f * longint'(LN2_Q30)) >> 24;
    term = 64'd1 << 30;
    sum = term;
    for (int i = 1; i <= 13; i++) begin
      term = ((term * r) >> 30) / i;
      sum += term;
    end
    sh = n - 6;
    if (sh >= 0) begin
      if (sh > 30) return 64'd1 << 61;
      return sum << sh;
    end
    if (-sh >= 63) return 0;
    return sum >> (-sh);
  endfunction

  function automatic void shape_in_use(output logic [15:0] b, output logic [11:0] g);
    if (beta_r == 0 || gamma_r == 0) begin
      b = FALLBACK_BETA;
      g = FALLBACK_GAMMA;
    end else begin
      b = beta_r;
      g = gamma_r;
    end
  endfunction

  function automatic void rebuild_constants();
    logic [15:0] b;
    logic [11:0] g;
    longint lnr, lwc;
    logic [31:0] sz;
    shape_in_use(b, g);
    peak_pow = 32'((64'(b) << 16) / g);
    lnr = log_q24(64'(b), 0) - log_q24(64'(g), 0);
    lwc = (lnr * 256) / longint'(g);
    if (lwc > 64'sd2147483647) lwc = 64'sd2147483647;
    if (lwc < -64'sd2147483648) lwc = -64'sd2147483648;
    ln_peak = 32'(lwc);
    sz = size_r;
    if (sz > (32'd1 << MAX_SIZE_LOG2)) sz = 32'd1 << MAX_SIZE_LOG2;
    step_q29 = sz ? 32'(64'(TWO_PI_Q29) / sz) : 0;
    half_n = 17'(sz / 2);
  endfunction

  function automatic logic [17:0] wavelet_at(logic [15:0] k);
    logic [15:0] b;
    logic [11:0] g;
    logic [63:0] w, wg, e, v;
    longint lnw, x;
    if (k == 0 || k > half_n) return 0;
    shape_in_use(b, g);
    w = 64'(k) * 64'(step_q29);
    if (w == 0) return 0;
    lnw = log_q24(w, 29);
    wg = exp_q24(shr_floor(lnw * longint'(g), 8));
    x = shr_floor((lnw - longint'(ln_peak)) * longint'(b), 8)
        + (longint'(peak_pow) <<< 8) - longint'(wg);
    if (x <= -80 * ONE_Q24 || x >= 80 * ONE_Q24) return 0;
    if (x >= 0) return OUT_MAX;
    e = exp_q24(x);
    v = e >> 7;
    if (v > 131072) v = 131072;
    return v[17:0];
  endfunction

  task automatic report(string what, logic [17:0] got, logic [17:0] exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $time);
    fail_count++;
  endtask

  assign pending = want_q.size();

  always @(posedge clk) begin
    if (rst) begin
      beta_r <= BETA_RESET;
      gamma_r <= GAMMA_RESET;
      size_r <= SIZE_RESET;
      want_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) report("unexpected beat", wavelet_value, 0);
        else begin
          logic [17:0] exp_v;
          exp_v = want_q.pop_front();
          if (wavelet_value !== exp_v) report("wavelet_value", wavelet_value, exp_v);
        end
      end
      if (in_valid && !in_stall) want_q.push_back(wavelet_at(bin_index));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BETA:  beta_r <= cfg_data[15:0];
          REG_GAMMA: gamma_r <= cfg_data[11:0];
          REG_SIZE:  size_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // constants follow the registers straight away
  always @(beta_r or gamma_r or size_r) rebuild_constants();

endmodule

@@ sim/tb_morse_wavelet_bin_generator.sv @@
// Testbench top for the Morse wavelet bin generator: clock, reset, bin and
// register stimulus, random output stalls. Checking lives in mwbg_checker.
// Depends on mwbg_pkg, morse_wavelet_bin_generator and mwbg_checker.
`timescale 1ns / 100ps
module tb_morse_wavelet_bin_generator;
  import mwbg_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [15:0] bin_index = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [17:0] wavelet_value;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_BETA;
  logic [16:0] cfg_data = 0;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          hold_off = 0;     // long receiver hold-off in force

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 200;   // covers the whole pipe depth plus margin

  morse_wavelet_bin_generator DUT (.*);

  mwbg_checker u_checker (.*);

  always #10 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL morse_wavelet_bin_generator");
      $finish;
    end
  end

  // receiver stalls: mostly short, some long, stretches of none
  int stall_mode = 0;
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (stall_mode == 0) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 99) < 25);
    if ($urandom_range(0, 299) == 0) stall_mode <= (stall_mode == 0);
  end

  // usually no gap or a short one, long gap now and then
  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
        ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one bin beat; valid stays high so the next beat can follow at once
  task automatic send_bin(logic [15:0] k);
    in_valid <= 1'b1;
    bin_index <= k;
    do @(posedge clk); while (in_stall);
  endtask

  // register write, only with the pipe drained
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // bins biased to the live half of the current size
  task automatic random_bins(int n, int half);
    logic [15:0] k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: k = 16'($urandom);
        1: k = 0;
        2: k = (half > 0) ? 16'(half) : 16'd1;
        default: k = (half > 0) ? 16'($urandom_range(1, half)) : 16'($urandom);
      endcase
      sender_gap();
      send_bin(k);
    end
  endtask

  int half;
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset shape, field extremes, out-of-range bins
    send_bin(16'd0);    send_bin(16'd1);    send_bin(16'd2);
    send_bin(16'd100);  send_bin(16'd300);  send_bin(16'd511);
    send_bin(16'd512);  send_bin(16'd513);  send_bin(16'hFFFF);
    send_bin(16'h5555); send_bin(16'h2AAA);

    // zero shape fallbacks, and odd register index ignored
    write_reg(REG_BETA, 17'd0);
    send_bin(16'd200);
    write_reg(REG_BETA, 17'h0FFFF);
    write_reg(REG_GAMMA, 17'd0);
    send_bin(16'd200);
    write_reg(REG_GAMMA, 17'h00FFF);
    send_bin(16'd1); send_bin(16'd512);
    write_reg(2'd3, 17'h1FFFF);
    // oversized and degenerate transforms
    write_reg(REG_SIZE, 17'h1FFFF);
    send_bin(16'd32768); send_bin(16'hFFFF); send_bin(16'd1);
    write_reg(REG_SIZE, 17'd1);
    send_bin(16'd1);
    write_reg(REG_SIZE, 17'd0);
    send_bin(16'd1);
    write_reg(REG_SIZE, 17'd2);
    send_bin(16'd1);

    // random phases over several shapes and sizes
    for (int ph = 0; ph < 10; ph++) begin
      int sz;
      write_reg(REG_BETA, (ph == 0) ? 17'd256 : 17'($urandom_range(1, 65535)));
      write_reg(REG_GAMMA, (ph == 1) ? 17'd1 : 17'($urandom_range(64, 4095)));
      sz = (ph == 2) ? 65536 : (ph == 3 ? 3 : $urandom_range(8, 4096));
      write_reg(REG_SIZE, 17'(sz));
      half = sz / 2;
      if (ph == 4) begin
        // block fills up while the receiver holds off
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
          random_bins(150, half);
        join
      end else
        random_bins(40, half);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) $display("PASS morse_wavelet_bin_generator");
    else $display("FAIL morse_wavelet_bin_generator");
    $finish;
  end

endmodule
